// ===== rtl/led_fade_dimmer_with_off_timer_macros.svh =====
// ----------------------------------------------------------------------------
// led_fade_dimmer_with_off_timer_macros
// Assertion macros shared by the dimmer RTL. Define ASSERT_OFF to drop them.
// ----------------------------------------------------------------------------
`ifndef LED_FADE_DIMMER_WITH_OFF_TIMER_MACROS_SVH
`define LED_FADE_DIMMER_WITH_OFF_TIMER_MACROS_SVH

`ifndef ASSERT_OFF

// Clocked assertion, disabled while reset is asserted (active low).
`define LFD_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Clocked assertion that also holds through reset.
`define LFD_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`else

`define LFD_ASSERT(lbl, clk, rst_n, prop, msg)
`define LFD_ASSERT_ALWAYS(lbl, clk, prop, msg)

`endif

`endif

// ===== rtl/lfd_pkg.sv =====
// ----------------------------------------------------------------------------
// lfd_pkg
// Types and constants of the LED fade dimmer with auto-off timer.
// ----------------------------------------------------------------------------
package lfd_pkg;

    typedef enum logic [2:0] {
        OP_TICK        = 3'd0,
        OP_SET_PERCENT = 3'd1,
        OP_SET_ABS     = 3'd2,
        OP_ON          = 3'd3,
        OP_OFF         = 3'd4,
        OP_TIMER_START = 3'd5,
        OP_LIGHT       = 3'd6
    } t_op;

    // configuration register indexes
    localparam logic [0:0] CFG_FADE_DELAY = 1'b0;
    localparam logic [0:0] CFG_LIGHT_THR  = 1'b1;

    localparam logic [7:0]  FADE_DELAY_RST = 8'd1;
    localparam logic [9:0]  LIGHT_THR_RST  = 10'd20;

    localparam logic [9:0]  LEVEL_FULL     = 10'd1000;
    localparam logic [6:0]  PERCENT_FULL   = 7'd100;
    localparam logic [9:0]  PERCENT_SCALE  = 10'd10;
    localparam logic [9:0]  MS_PER_SECOND  = 10'd1000;
    localparam logic [26:0] ELAPSED_MAX    = 27'h7FF_FFFF;
    localparam logic [7:0]  DELAY_CNT_MAX  = 8'd255;

    // x / 10 = (x * 205) >> 11, exact for x < 1029
    localparam logic [7:0]  DIV10_MUL      = 8'd205;
    // x / 1000 = (x * 1073742) >> 30, exact for x < 2^20
    localparam logic [20:0] DIV1000_MUL    = 21'd1073742;

    typedef struct packed {
        logic [2:0]  operation;
        logic [9:0]  level_request;
        logic [15:0] timer_seconds;
        logic [9:0]  light_sample;
    } t_in;

    typedef struct packed {
        logic [9:0]  pwm_duty;
        logic [9:0]  level_now;
        logic [6:0]  percent_now;
        logic        fade_finished;
        logic [15:0] timer_armed_seconds;
        logic        light_report_valid;
        logic [9:0]  light_reported;
    } t_out;

    // result fields after the state update, before the duty is computed
    typedef struct packed {
        logic [9:0]  level_now;
        logic [6:0]  percent_now;
        logic        fade_finished;
        logic [15:0] timer_armed_seconds;
        logic        light_report_valid;
        logic [9:0]  light_reported;
    } t_stage;

endpackage

// ===== rtl/lfd_core.sv =====
// ----------------------------------------------------------------------------
// lfd_core
// Dimmer state, configuration registers and the per-transaction update.
// Registers the updated result fields for the duty pipeline.
// ----------------------------------------------------------------------------
module lfd_core
    import lfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_wdata,
    input  logic        i_accept,
    input  t_in         i_in_data,
    input  logic        i_ready,
    output logic        o_valid,
    output t_stage      o_data
);

    logic [7:0]  r_fade_delay;
    logic [9:0]  r_light_thr;

    logic [9:0]  r_level,        n_level;
    logic [9:0]  r_target,       n_target;
    logic        r_step_down,    n_step_down;
    logic [6:0]  r_percent,      n_percent;
    logic [7:0]  r_fade_elapsed, n_fade_elapsed;
    logic [15:0] r_limit_s,      n_limit_s;
    logic [25:0] r_limit_ms,     n_limit_ms;
    logic [26:0] r_off_elapsed,  n_off_elapsed;
    logic [9:0]  r_light_last,   n_light_last;

    logic        r_valid;
    t_stage      r_stage;

    logic        finished;
    logic        reported;
    logic        fade_start;
    logic [9:0]  fade_to;
    logic [8:0]  cnt;
    logic [26:0] elapsed_inc;
    logic        expired;
    logic [9:0]  cur_step;
    logic [17:0] pct_prod;
    logic [6:0]  pct_req;
    logic [9:0]  abs_req;
    logic [9:0]  diff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fade_delay <= FADE_DELAY_RST;
            r_light_thr  <= LIGHT_THR_RST;
        end else if (i_cfg_wr_en) begin
            unique case (i_cfg_index)
                CFG_FADE_DELAY: r_fade_delay <= i_cfg_wdata[7:0];
                CFG_LIGHT_THR:  r_light_thr  <= i_cfg_wdata;
                default:        r_light_thr  <= r_light_thr;
            endcase
        end
    end

    always_comb begin
        n_level        = r_level;
        n_target       = r_target;
        n_step_down    = r_step_down;
        n_percent      = r_percent;
        n_fade_elapsed = r_fade_elapsed;
        n_limit_s      = r_limit_s;
        n_limit_ms     = r_limit_ms;
        n_off_elapsed  = r_off_elapsed;
        n_light_last   = r_light_last;
        finished       = 1'b0;
        reported       = 1'b0;
        fade_start     = 1'b0;
        fade_to        = '0;

        cnt         = {1'b0, r_fade_elapsed} + 9'd1;
        elapsed_inc = (r_off_elapsed < ELAPSED_MAX) ? r_off_elapsed + 27'd1 : r_off_elapsed;
        expired     = (r_limit_s != '0) && (elapsed_inc > {1'b0, r_limit_ms});
        cur_step    = r_step_down ? r_level - 10'd1 : r_level + 10'd1;
        pct_prod    = {8'd0, cur_step} * {10'd0, DIV10_MUL};
        pct_req     = (i_in_data.level_request > {3'd0, PERCENT_FULL}) ?
                      PERCENT_FULL : i_in_data.level_request[6:0];
        abs_req     = (i_in_data.level_request > LEVEL_FULL) ?
                      LEVEL_FULL : i_in_data.level_request;
        diff        = (i_in_data.light_sample >= r_light_last) ?
                      i_in_data.light_sample - r_light_last :
                      r_light_last - i_in_data.light_sample;

        unique case (i_in_data.operation)
            OP_TICK: begin
                if (r_limit_s != '0) begin
                    n_off_elapsed = elapsed_inc;
                end
                if (expired) begin
                    // timer ran out: fade to off, no step this tick
                    n_limit_s  = '0;
                    fade_start = 1'b1;
                    fade_to    = '0;
                end else begin
                    n_fade_elapsed = (cnt > {1'b0, DELAY_CNT_MAX}) ? DELAY_CNT_MAX : cnt[7:0];
                    if ((r_target != r_level) && (cnt > {1'b0, r_fade_delay})) begin
                        n_level        = cur_step;
                        n_fade_elapsed = '0;
                        if (r_target == cur_step) begin
                            n_percent = (r_target == LEVEL_FULL) ? PERCENT_FULL : pct_prod[17:11];
                            finished  = 1'b1;
                        end
                    end
                end
            end
            OP_SET_PERCENT: begin
                n_limit_s = '0;
                if (i_in_data.level_request != '0) begin
                    if (pct_req != r_percent) begin
                        fade_start = 1'b1;
                        fade_to    = 10'({3'd0, pct_req} * PERCENT_SCALE);
                    end
                end else if (r_percent != '0) begin
                    fade_start = 1'b1;
                end
            end
            OP_SET_ABS: begin
                n_limit_s = '0;
                if (i_in_data.level_request != '0) begin
                    if (abs_req != r_level) begin
                        fade_start = 1'b1;
                        fade_to    = abs_req;
                    end
                end else if (r_level != '0) begin
                    fade_start = 1'b1;
                end
            end
            OP_ON: begin
                n_limit_s  = '0;
                fade_start = 1'b1;
                fade_to    = LEVEL_FULL;
            end
            OP_OFF: begin
                n_limit_s  = '0;
                fade_start = 1'b1;
            end
            OP_TIMER_START: begin
                if (i_in_data.timer_seconds != '0) begin
                    if (r_percent == '0) begin
                        fade_start = 1'b1;
                        fade_to    = LEVEL_FULL;
                    end
                    n_limit_s     = i_in_data.timer_seconds;
                    n_limit_ms    = 26'({10'd0, i_in_data.timer_seconds} * {16'd0, MS_PER_SECOND});
                    n_off_elapsed = '0;
                end
            end
            OP_LIGHT: begin
                if (diff > r_light_thr) begin
                    n_light_last = i_in_data.light_sample;
                    reported     = 1'b1;
                end
            end
            default: begin
                // unused code: state unchanged
                reported = 1'b0;
            end
        endcase

        if (fade_start) begin
            n_target       = fade_to;
            n_step_down    = (fade_to < r_level);
            n_fade_elapsed = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level        <= '0;
            r_target       <= '0;
            r_step_down    <= 1'b0;
            r_percent      <= '0;
            r_fade_elapsed <= '0;
            r_limit_s      <= '0;
            r_limit_ms     <= '0;
            r_off_elapsed  <= '0;
            r_light_last   <= '0;
            r_valid        <= 1'b0;
        end else begin
            if (i_accept) begin
                r_level        <= n_level;
                r_target       <= n_target;
                r_step_down    <= n_step_down;
                r_percent      <= n_percent;
                r_fade_elapsed <= n_fade_elapsed;
                r_limit_s      <= n_limit_s;
                r_limit_ms     <= n_limit_ms;
                r_off_elapsed  <= n_off_elapsed;
                r_light_last   <= n_light_last;
            end
            if (i_ready || !r_valid) begin
                r_valid <= i_accept;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_stage.level_now           <= n_level;
            r_stage.percent_now         <= n_percent;
            r_stage.fade_finished       <= finished;
            r_stage.timer_armed_seconds <= n_limit_s;
            r_stage.light_report_valid  <= reported;
            r_stage.light_reported      <= n_light_last;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_stage;

endmodule

// ===== rtl/lfd_duty.sv =====
// ----------------------------------------------------------------------------
// lfd_duty
// Two-stage duty pipeline: level squared, then divide by 1000 through a
// reciprocal multiply. The last stage is the output register.
// ----------------------------------------------------------------------------
module lfd_duty
    import lfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    input  t_stage      i_data,
    output logic        o_ready,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data
);

    logic        r_v2;
    logic [19:0] r_square;
    t_stage      r_s2;
    logic        r_v3;
    t_out        r_out;

    logic        ready2;
    logic        ready3;
    logic [40:0] scaled;

    assign ready3  = !r_v3 || !i_out_stall;
    assign ready2  = !r_v2 || ready3;
    assign o_ready = ready2;
    assign scaled  = {21'd0, r_square} * {20'd0, DIV1000_MUL};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (ready2) begin
                r_v2 <= i_valid;
            end
            if (ready3) begin
                r_v3 <= r_v2;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && ready2) begin
            r_square <= {10'd0, i_data.level_now} * {10'd0, i_data.level_now};
            r_s2     <= i_data;
        end
        if (r_v2 && ready3) begin
            r_out.pwm_duty            <= scaled[39:30];
            r_out.level_now           <= r_s2.level_now;
            r_out.percent_now         <= r_s2.percent_now;
            r_out.fade_finished       <= r_s2.fade_finished;
            r_out.timer_armed_seconds <= r_s2.timer_armed_seconds;
            r_out.light_report_valid  <= r_s2.light_report_valid;
            r_out.light_reported      <= r_s2.light_reported;
        end
    end

    assign o_out_valid = r_v3;
    assign o_out_data  = r_out;

endmodule

// ===== rtl/led_fade_dimmer_with_off_timer.sv =====
// ----------------------------------------------------------------------------
// led_fade_dimmer_with_off_timer
// LED fade dimmer with auto-off timer and light-change reporter.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data) carries one operation
//   per transaction: tick, set percent, set absolute, on, off, timer start or
//   light sample. Output channel (o_out_valid / i_out_stall / o_out_data)
//   returns exactly one result per input transaction, in order.
//   Config port: i_cfg_wr_en with i_cfg_index / i_cfg_wdata writes the fade
//   step delay (index 0) or the light threshold (index 1); write only idle.
//   Pipeline: the registered state update, then a square stage and a
//   reciprocal divide-by-1000 stage. Throughput: one transaction per cycle
//   while the output is not stalled.
//   Reset (i_rst_n low, synchronous): all dimmer state cleared, registers
//   back to delay 1 and threshold 20, pipeline empty.
//   Output stall: the result register holds; up to two more transactions are
//   taken into the pipeline, then o_in_stall rises until the output drains.
// ----------------------------------------------------------------------------
`include "led_fade_dimmer_with_off_timer_macros.svh"

module led_fade_dimmer_with_off_timer
    import lfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_wdata
);

    logic   s1_valid;
    t_stage s1_data;
    logic   s1_ready;
    logic   core_ready;
    logic   accept;

    assign core_ready = !s1_valid || s1_ready;
    assign o_in_stall = !core_ready;
    assign accept     = i_in_valid && core_ready;

    lfd_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wr_en (i_cfg_wr_en),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_accept    (accept),
        .i_in_data   (i_in_data),
        .i_ready     (s1_ready),
        .o_valid     (s1_valid),
        .o_data      (s1_data)
    );

    lfd_duty u_duty (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s1_valid),
        .i_data      (s1_data),
        .o_ready     (s1_ready),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data)
    );

    // input side only backs up when the whole pipeline is full and stalled
    `LFD_ASSERT(a_stall_needs_full, i_clk, i_rst_n, (o_in_stall |-> (o_out_valid && i_out_stall)), "input stalled while output not blocked")

    `LFD_ASSERT(a_level_range, i_clk, i_rst_n, (o_out_valid |-> (o_out_data.level_now <= LEVEL_FULL)), "level above full scale")

    `LFD_ASSERT(a_duty_le_level, i_clk, i_rst_n, (o_out_valid |-> (o_out_data.pwm_duty <= o_out_data.level_now)), "duty above level")

    `LFD_ASSERT(a_finish_percent, i_clk, i_rst_n, ((o_out_valid && o_out_data.fade_finished) |-> (({4'd0, o_out_data.percent_now} * 11'd10) <= {1'b0, o_out_data.level_now})), "settled percent inconsistent with level")

endmodule

// ===== dv/dimmer_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dimmer_checker
// Watches the input, output and register ports of the LED dimmer, keeps its
// own copy of the dimmer state, predicts one result per input transaction
// and compares every output transaction field by field, in order.
// ----------------------------------------------------------------------------
module dimmer_checker
    import lfd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  t_in         i_in_data,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  t_out        i_out_data,
    input  logic        i_cfg_wr_en,
    input  logic [0:0]  i_cfg_index,
    input  logic [9:0]  i_cfg_wdata,
    output int          o_fail_count,
    output int          o_pending
);

    localparam int unsigned FULL_LEVEL        = 1000;
    localparam int unsigned FULL_PERCENT      = 100;
    localparam int unsigned LEVEL_PER_PERCENT = 10;
    localparam int unsigned MS_PER_S          = 1000;
    localparam int unsigned OFF_MS_MAX        = 134217727;
    localparam int unsigned FADE_MS_MAX       = 255;
    localparam int          MAX_PRINTED       = 100;

    logic [7:0]  step_delay_ms;
    logic [9:0]  light_threshold;

    logic [9:0]  level_cur;
    logic [9:0]  level_goal;
    logic        fading_down;
    logic [6:0]  percent_held;
    logic [7:0]  fade_ms;
    logic [15:0] off_limit_s;
    logic [26:0] off_ms;
    logic [9:0]  light_last;

    t_out        results_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    task automatic report_failure(input string msg);
        if (o_fail_count < MAX_PRINTED) begin
            $display("[%0t] mismatch: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_failure($sformatf("%s got %0d, expected %0d", name, got, want));
        end
    endtask

    function automatic void clear_dimmer();
        step_delay_ms   = FADE_DELAY_RST;
        light_threshold = LIGHT_THR_RST;
        level_cur       = '0;
        level_goal      = '0;
        fading_down     = 1'b0;
        percent_held    = '0;
        fade_ms         = '0;
        off_limit_s     = '0;
        off_ms          = '0;
        light_last      = '0;
    endfunction

    function automatic void begin_fade(input logic [9:0] goal);
        level_goal  = goal;
        fading_down = (goal < level_cur);
        fade_ms     = '0;
    endfunction

    // applies one transaction to the dimmer copy and returns its result
    function automatic t_out dimmer_step(input t_in txn);
        t_out        res;
        logic [9:0]  req;
        logic        expired;
        int unsigned cnt;
        int unsigned diff;
        int unsigned limit_ms;
        int unsigned square;
        res     = '0;
        req     = txn.level_request;
        expired = 1'b0;
        case (txn.operation)
            OP_TICK: begin
                // timer goes first; an expiring tick does not step the fade
                if (off_limit_s != 0) begin
                    if (off_ms < OFF_MS_MAX) off_ms++;
                    limit_ms = off_limit_s * MS_PER_S;
                    if (off_ms > limit_ms) begin
                        off_limit_s = '0;
                        begin_fade('0);
                        expired = 1'b1;
                    end
                end
                if (!expired) begin
                    cnt     = fade_ms + 1;
                    fade_ms = (cnt > FADE_MS_MAX) ? FADE_MS_MAX[7:0] : cnt[7:0];
                    if (level_goal != level_cur && cnt > step_delay_ms) begin
                        level_cur = fading_down ? level_cur - 10'd1 : level_cur + 10'd1;
                        fade_ms   = '0;
                        if (level_goal == level_cur) begin
                            if (level_goal == FULL_LEVEL) percent_held = FULL_PERCENT[6:0];
                            else percent_held = 7'(level_cur / LEVEL_PER_PERCENT);
                            res.fade_finished = 1'b1;
                        end
                    end
                end
            end
            OP_SET_PERCENT: begin
                off_limit_s = '0;
                if (req != 0) begin
                    if (req > FULL_PERCENT) req = FULL_PERCENT[9:0];
                    if (req != percent_held) begin_fade(10'(req * LEVEL_PER_PERCENT));
                end else if (percent_held != 0) begin
                    begin_fade('0);
                end
            end
            OP_SET_ABS: begin
                off_limit_s = '0;
                if (req != 0) begin
                    if (req > FULL_LEVEL) req = FULL_LEVEL[9:0];
                    if (req != level_cur) begin_fade(req);
                end else if (level_cur != 0) begin
                    begin_fade('0);
                end
            end
            OP_ON: begin
                off_limit_s = '0;
                begin_fade(FULL_LEVEL[9:0]);
            end
            OP_OFF: begin
                off_limit_s = '0;
                begin_fade('0);
            end
            OP_TIMER_START: begin
                if (txn.timer_seconds != 0) begin
                    if (percent_held == 0) begin_fade(FULL_LEVEL[9:0]);
                    off_limit_s = txn.timer_seconds;
                    off_ms      = '0;
                end
            end
            OP_LIGHT: begin
                if (txn.light_sample >= light_last) diff = txn.light_sample - light_last;
                else diff = light_last - txn.light_sample;
                if (diff > light_threshold) begin
                    light_last             = txn.light_sample;
                    res.light_report_valid = 1'b1;
                end
            end
            default: ;
        endcase
        square                  = level_cur * level_cur;
        res.pwm_duty            = 10'(square / FULL_LEVEL);
        res.level_now           = level_cur;
        res.percent_now         = percent_held;
        res.timer_armed_seconds = off_limit_s;
        res.light_reported      = light_last;
        return res;
    endfunction

    always @(posedge i_clk) begin
        t_out want;
        if (!i_rst_n) begin
            clear_dimmer();
            results_due.delete();
        end else begin
            if (i_cfg_wr_en) begin
                case (i_cfg_index)
                    CFG_FADE_DELAY: step_delay_ms = i_cfg_wdata[7:0];
                    CFG_LIGHT_THR:  light_threshold = i_cfg_wdata;
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (results_due.size() == 0) begin
                    report_failure("output transaction with no result due");
                end else begin
                    want = results_due.pop_front();
                    compare_field("pwm_duty", i_out_data.pwm_duty, want.pwm_duty);
                    compare_field("level_now", i_out_data.level_now, want.level_now);
                    compare_field("percent_now", i_out_data.percent_now, want.percent_now);
                    compare_field("fade_finished", i_out_data.fade_finished,
                                  want.fade_finished);
                    compare_field("timer_armed_seconds", i_out_data.timer_armed_seconds,
                                  want.timer_armed_seconds);
                    compare_field("light_report_valid", i_out_data.light_report_valid,
                                  want.light_report_valid);
                    compare_field("light_reported", i_out_data.light_reported,
                                  want.light_reported);
                end
            end
            if (i_in_valid && !i_in_stall) begin
                results_due.push_back(dimmer_step(i_in_data));
            end
        end
        o_pending = results_due.size();
    end

endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives the LED dimmer with directed and random operations in bursts, stalls
// the result side on changing patterns, reprograms the fade delay and light
// threshold between phases and lets dimmer_checker judge every result.
// ----------------------------------------------------------------------------
module testbench;
    import lfd_pkg::*;

    localparam logic [2:0] OP_RESERVED  = 3'd7;
    localparam int         PIPE_LATENCY = 3;
    localparam int         IDLE_LIMIT   = 1000;

    logic        clk         = 1'b0;
    logic        rst_n       = 1'b0;
    logic        in_valid    = 1'b0;
    logic        in_stall;
    t_in         in_data     = '0;
    logic        out_valid;
    logic        out_stall   = 1'b0;
    t_out        out_data;
    logic        cfg_wr_en   = 1'b0;
    logic [0:0]  cfg_index   = CFG_FADE_DELAY;
    logic [9:0]  cfg_wdata   = '0;

    int          fail_count;
    int          pending;
    int          burst_left  = 0;
    bit          valid_up    = 1'b0;
    int          idle_cycles = 0;
    int          stall_mode  = 0;
    int          stall_left  = 0;

    always #2 clk = ~clk;

    led_fade_dimmer_with_off_timer dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_in_data   (in_data),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_data  (out_data),
        .i_cfg_wr_en (cfg_wr_en),
        .i_cfg_index (cfg_index),
        .i_cfg_wdata (cfg_wdata)
    );

    dimmer_checker dimmer_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_in_data    (in_data),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_data   (out_data),
        .i_cfg_wr_en  (cfg_wr_en),
        .i_cfg_index  (cfg_index),
        .i_cfg_wdata  (cfg_wdata),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    // result side: stall density switches among three randomly drawn modes
    always @(posedge clk) begin
        if (stall_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            stall_left = $urandom_range(20, 150);
        end else begin
            stall_left--;
        end
        case (stall_mode)
            0: out_stall <= 1'b0;
            1: out_stall <= ($urandom_range(0, 3) == 0);
            default: out_stall <= ($urandom_range(0, 9) < 8);
        endcase
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= IDLE_LIMIT) begin
            $display("RESULT: ERROR");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    function automatic t_in mk_txn(input logic [2:0] op, input logic [9:0] req,
                                   input logic [15:0] secs, input logic [9:0] light);
        t_in txn;
        txn.operation     = op;
        txn.level_request = req;
        txn.timer_seconds = secs;
        txn.light_sample  = light;
        return txn;
    endfunction

    // mostly ticks; requests lean toward small levels so fades finish
    function automatic t_in rand_txn();
        t_in txn;
        int  pick;
        txn  = mk_txn(OP_TICK, 10'($urandom_range(0, 1023)), 16'($urandom_range(0, 65535)),
                      10'($urandom_range(0, 1023)));
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
            txn.operation = OP_TICK;
        end else if (pick < 67) begin
            txn.operation = OP_LIGHT;
        end else if (pick < 77) begin
            txn.operation = OP_SET_ABS;
            if ($urandom_range(0, 1) == 0) txn.level_request = 10'($urandom_range(0, 40));
        end else if (pick < 84) begin
            txn.operation = OP_SET_PERCENT;
            if ($urandom_range(0, 1) == 0) txn.level_request = 10'($urandom_range(0, 5));
        end else if (pick < 87) begin
            txn.operation = OP_ON;
        end else if (pick < 90) begin
            txn.operation = OP_OFF;
        end else if (pick < 97) begin
            txn.operation = OP_TIMER_START;
            case ($urandom_range(0, 2))
                0: txn.timer_seconds = '0;
                1: txn.timer_seconds = 16'($urandom_range(1, 2));
                default: ;
            endcase
        end else begin
            txn.operation = OP_RESERVED;
        end
        return txn;
    endfunction

    // holds the transaction until accepted, then maybe opens a gap
    task automatic send_txn(input t_in txn);
        int gap;
        in_valid <= 1'b1;
        in_data  <= txn;
        valid_up = 1'b1;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            gap        = $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(0, 12);
            in_valid <= 1'b0;
            valid_up = 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic wait_drained();
        if (valid_up) begin
            in_valid <= 1'b0;
            valid_up = 1'b0;
        end
        @(posedge clk);
        while (pending != 0) @(posedge clk);
    endtask

    task automatic set_config(input logic [7:0] delay_ms, input logic [9:0] threshold);
        wait_drained();
        repeat (PIPE_LATENCY + 2) @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= CFG_FADE_DELAY;
        cfg_wdata <= {2'b00, delay_ms};
        @(posedge clk);
        cfg_index <= CFG_LIGHT_THR;
        cfg_wdata <= threshold;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic run_mix(input int count);
        repeat (count) begin
            send_txn(rand_txn());
            if ($urandom_range(0, 49) == 0) wait_drained();
        end
    endtask

    initial begin
        int ticks;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // directed: reset registers, field extremes, all operations
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_LIGHT, 10'd0, 16'd0, 10'd1023));
        send_txn(mk_txn(OP_LIGHT, 10'd0, 16'd0, 10'd1003));   // change at threshold
        send_txn(mk_txn(OP_LIGHT, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_SET_ABS, 10'd1, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_SET_ABS, 10'd1, 16'd0, 10'd0));     // equal to current
        send_txn(mk_txn(OP_SET_PERCENT, 10'd1023, 16'd0, 10'd0));
        send_txn(mk_txn(OP_SET_PERCENT, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_SET_ABS, 10'd1023, 16'd0, 10'd0));
        send_txn(mk_txn(OP_SET_ABS, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TIMER_START, 10'd0, 16'd65535, 10'd0)); // armed while off
        send_txn(mk_txn(OP_TIMER_START, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_ON, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_OFF, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_RESERVED, 10'd1023, 16'd65535, 10'd1023));
        send_txn(mk_txn(OP_SET_PERCENT, 10'd1, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));
        send_txn(mk_txn(OP_TICK, 10'd0, 16'd0, 10'd0));

        set_config(8'd0, 10'd0);
        run_mix(400);

        // one-second auto-off: fade keeps running under the timer until expiry
        send_txn(mk_txn(OP_TIMER_START, 10'($urandom_range(0, 1023)), 16'd1,
                        10'($urandom_range(0, 1023))));
        ticks = 0;
        while (ticks < 1008) begin
            if ($urandom_range(0, 9) == 0) begin
                send_txn(mk_txn(($urandom_range(0, 1) == 0) ? OP_LIGHT : OP_TIMER_START,
                                10'($urandom_range(0, 1023)), 16'd0,
                                10'($urandom_range(0, 1023))));
            end else begin
                send_txn(mk_txn(OP_TICK, 10'($urandom_range(0, 1023)),
                                16'($urandom_range(0, 65535)),
                                10'($urandom_range(0, 1023))));
                ticks++;
            end
        end

        // longest fade delay: the step count saturates before the step
        set_config(8'd255, 10'd1023);
        send_txn(mk_txn(OP_SET_ABS, 10'($urandom_range(1, 1000)), 16'd0, 10'd0));
        repeat (300) begin
            if ($urandom_range(0, 19) == 0) begin
                send_txn(mk_txn(OP_LIGHT, 10'd0, 16'd0, 10'($urandom_range(0, 1023))));
            end else begin
                send_txn(mk_txn(OP_TICK, 10'($urandom_range(0, 1023)),
                                16'($urandom_range(0, 65535)),
                                10'($urandom_range(0, 1023))));
            end
        end

        set_config(8'($urandom_range(2, 254)), 10'($urandom_range(1, 1022)));
        run_mix(150);

        wait_drained();
        repeat (PIPE_LATENCY + 5) @(posedge clk);
        if (fail_count == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
